[rtl/stt_pkg.sv]
// Package: token codes, scanner modes, error codes and the result item type.
`default_nettype none
package stt_pkg;

    typedef enum logic [3:0] {
        M_IDLE, M_SLASH, M_COMMENT, M_EQ, M_EQSLASH, M_LT, M_GT,
        M_INT, M_DOT, M_FRAC, M_IDENT, M_STR, M_PCT
    } t_mode;

    localparam logic [5:0] K_ERR = 6'd0;
    localparam logic [5:0] K_EOF = 6'd1;
    localparam logic [5:0] K_COMMENT = 6'd2;
    localparam logic [5:0] K_LPAREN = 6'd3;
    localparam logic [5:0] K_RPAREN = 6'd4;
    localparam logic [5:0] K_LBRACE = 6'd5;
    localparam logic [5:0] K_RBRACE = 6'd6;
    localparam logic [5:0] K_COMMA = 6'd7;
    localparam logic [5:0] K_DOT = 6'd8;
    localparam logic [5:0] K_MINUS = 6'd9;
    localparam logic [5:0] K_PLUS = 6'd10;
    localparam logic [5:0] K_SLASH = 6'd11;
    localparam logic [5:0] K_STAR = 6'd12;
    localparam logic [5:0] K_CARET = 6'd13;
    localparam logic [5:0] K_SEMI = 6'd14;
    localparam logic [5:0] K_EQ = 6'd15;
    localparam logic [5:0] K_EQEQ = 6'd16;
    localparam logic [5:0] K_NE = 6'd17;
    localparam logic [5:0] K_LT = 6'd18;
    localparam logic [5:0] K_LE = 6'd19;
    localparam logic [5:0] K_GT = 6'd20;
    localparam logic [5:0] K_GE = 6'd21;
    localparam logic [5:0] K_NUM = 6'd22;
    localparam logic [5:0] K_STR = 6'd23;
    localparam logic [5:0] K_INTERP = 6'd24;
    localparam logic [5:0] K_IDENT = 6'd25;
    localparam logic [5:0] K_KW0 = 6'd26;
    localparam int NKW = 19;

    localparam logic [2:0] E_NONE = 3'd0;
    localparam logic [2:0] E_UNKNOWN = 3'd1;
    localparam logic [2:0] E_UNTERM = 3'd2;
    localparam logic [2:0] E_PERCENT = 3'd3;
    localparam logic [2:0] E_DEEP = 3'd4;

    localparam logic [15:0] LEN_TOP = 16'hFFFF;

    // keyword spellings, first byte in the low bits, zero padded
    localparam logic [55:0] KW_TEXT [NKW] = '{
        56'h65, 56'h756f, 56'h616b, 56'h69_73616c6b, 56'h696c656b, 56'h6973,
        56'h75_6f6e6973, 56'h72_65707573, 56'h75_73_6c6166, 56'h6e6f_73_6e7566,
        56'h6964, 56'h69_766c_6f766964, 56'h6974, 56'h69_746e_656d6974,
        56'h69_6d69_7270_6d69, 56'h69_6461_6472_6576, 56'h61_6972_6f6d_696d,
        56'h6f6c756e, 56'h6170
    };
    localparam logic [2:0] KW_LEN [NKW] = '{
        3'd1, 3'd2, 3'd2, 3'd5, 3'd4, 3'd2, 3'd5, 3'd5, 3'd5, 3'd6,
        3'd2, 3'd7, 3'd2, 3'd7, 3'd7, 3'd7, 3'd7, 3'd4, 3'd2
    };

    typedef struct packed {
        logic [5:0]  kind;
        logic [23:0] offset;
        logic [15:0] length;
        logic [15:0] line;
        logic [2:0]  err;
        logic        last;
    } t_tok;

endpackage
`default_nettype wire

[rtl/stt_if.sv]
// Interfaces: byte input channel and token output channel.
`default_nettype none
interface stt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    modport source (output valid, output text_byte, input ready);
    modport sink (input valid, input text_byte, output ready);
endinterface

interface stt_tok_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_code;
    logic [23:0] token_offset;
    logic [15:0] token_length;
    logic [15:0] token_line;
    logic [2:0]  error_code;
    logic        last_of_run;
    modport source (output valid, output token_code, output token_offset,
                    output token_length, output token_line, output error_code,
                    output last_of_run, input ready);
    modport sink (input valid, input token_code, input token_offset,
                  input token_length, input token_line, input error_code,
                  input last_of_run, output ready);
endinterface
`default_nettype wire

[rtl/source_text_tokenizer_top.sv]
// Top level: streaming tokenizer, one byte per item, up to three tokens out.
// A token is registered and appears in the cycle after the byte that completes it.
// Throughput: one byte per cycle while the output is ready; the three-entry token queue
// drains one per cycle, and the next byte is taken when it is empty or its last leaves.
// Reset: synchronous active low; line 1, offset 0, idle mode, queue empty.
// Brace counts are not cleared; entries are written before they are read.
`default_nettype none
module source_text_tokenizer_top #(
    parameter int INTERP_MAX  = 8,
    parameter int OFFSET_BITS = 24
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    stt_byte_if.sink  i_in,
    stt_tok_if.source o_out
);
    import stt_pkg::*;

    localparam int DW = $clog2(INTERP_MAX + 1);
    localparam int IW = (INTERP_MAX > 1) ? $clog2(INTERP_MAX) : 1;
    localparam logic [OFFSET_BITS-1:0] OFF_TOP = '1;

    // scanner state
    t_mode                  r_mode, n_mode;
    logic [15:0]            r_line, n_line;
    logic [OFFSET_BITS-1:0] r_off, r_start, n_start, r_prev;
    logic [15:0]            r_len, n_len;
    logic [55:0]            r_kw, n_kw;
    logic [DW-1:0]          r_depth, n_depth;
    logic [7:0]             r_brace [INTERP_MAX];
    logic [7:0]             r_top_bc;
    logic                   brace_we;
    logic                   brace_pop;
    logic [IW-1:0]          brace_wa;
    logic [7:0]             brace_wd;

    // result queue
    t_tok     r_q [3];
    logic [1:0] r_qn;
    t_tok     n_t [3];
    logic [1:0] n_cnt;

    logic acc;
    assign i_in.ready = (r_qn == 2'd0) || (r_qn == 2'd1 && o_out.ready);
    assign acc = i_in.valid && i_in.ready;

    function automatic logic is_dig(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction
    function automatic logic is_alp(input logic [7:0] b);
        return b == 8'h5f || (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
    endfunction
    function automatic logic [15:0] ladd(input logic [15:0] x, input logic [1:0] k);
        logic [16:0] s;
        s = {1'b0, x} + {15'd0, k};
        return s[16] ? LEN_TOP : s[15:0];
    endfunction
    function automatic logic [23:0] o24(input logic [OFFSET_BITS-1:0] o);
        logic [31:0] w;
        w = 32'(o);
        return w[23:0];
    endfunction

    // keyword lookup on the buffered identifier
    logic [5:0] id_kind;
    always_comb begin
        id_kind = K_IDENT;
        if (r_len <= 16'd7) begin
            for (int i = NKW - 1; i >= 0; i--) begin
                if (16'(KW_LEN[i]) == r_len && KW_TEXT[i] == r_kw)
                    id_kind = K_KW0 + 6'(i);
            end
        end
    end

    logic [IW-1:0] top_i;
    assign top_i = IW'(r_depth - DW'(1));

    // one byte through the scanner: up to two fed characters
    always_comb begin
        t_mode m;
        logic [7:0] b;
        logic [OFFSET_BITS-1:0] o;
        logic fin, rst;
        logic [7:0] sb [3];
        logic [OFFSET_BITS-1:0] so [3];
        logic [1:0] ns;
        n_mode = r_mode; n_line = r_line; n_start = r_start; n_len = r_len;
        n_kw = r_kw; n_depth = r_depth;
        brace_we = 1'b0; brace_pop = 1'b0; brace_wa = top_i; brace_wd = 8'd0;
        n_cnt = 2'd0; rst = 1'b0;
        m = M_IDLE; b = 8'd0; o = '0; fin = 1'b0;
        for (int k = 0; k < 3; k++) n_t[k] = '0;
        // sequence of characters to feed: lookahead replay for "=/" and "n."
        sb[0] = i_in.text_byte; so[0] = r_off; sb[1] = i_in.text_byte;
        so[1] = r_off; sb[2] = i_in.text_byte; so[2] = r_off; ns = 2'd1;
        if ((r_mode == M_EQSLASH && i_in.text_byte != 8'h3d) ||
            (r_mode == M_DOT && !is_dig(i_in.text_byte))) begin
            sb[0] = (r_mode == M_EQSLASH) ? 8'h2f : 8'h2e; so[0] = r_prev;
            ns = 2'd2;
        end
        if (r_mode == M_EQSLASH && i_in.text_byte != 8'h3d) begin
            n_t[0] = '{K_EQ, o24(r_start), 16'd1, r_line, E_NONE, 1'b0};
            n_cnt = 2'd1; n_mode = M_IDLE;
        end else if (r_mode == M_DOT && !is_dig(i_in.text_byte)) begin
            n_t[0] = '{K_NUM, o24(r_start), r_len, r_line, E_NONE, 1'b0};
            n_cnt = 2'd1; n_mode = M_IDLE;
        end
        for (int s = 0; s < 3; s++) begin
            if (2'(s) < ns && !rst) begin
                b = sb[s]; o = so[s]; m = n_mode; fin = 1'b1;
                // continuation of a pending token; fin=0 means fall to idle
                unique case (m) inside
                    M_IDLE: fin = 1'b0;
                    M_SLASH: begin
                        if (b == 8'h2f) begin n_len = 16'd2; n_mode = M_COMMENT; end
                        else begin
                            n_t[n_cnt] = '{K_SLASH, o24(n_start), 16'd1, n_line, E_NONE, 1'b0};
                            n_cnt = n_cnt + 2'd1; fin = 1'b0;
                        end
                    end
                    M_COMMENT: begin
                        if (b != 8'h0a && b != 8'h00) n_len = ladd(n_len, 2'd1);
                        else begin
                            n_t[n_cnt] = '{K_COMMENT, o24(n_start), n_len, n_line,
                                           E_NONE, 1'b0};
                            n_cnt = n_cnt + 2'd1; fin = 1'b0;
                        end
                    end
                    M_EQ: begin
                        if (b == 8'h2f) begin n_len = 16'd2; n_mode = M_EQSLASH; end
                        else if (b == 8'h3d) begin
                            n_t[n_cnt] = '{K_EQEQ, o24(n_start), 16'd2, n_line, E_NONE, 1'b0};
                            n_cnt = n_cnt + 2'd1; n_mode = M_IDLE;
                        end else begin
                            n_t[n_cnt] = '{K_EQ, o24(n_start), 16'd1, n_line, E_NONE, 1'b0};
                            n_cnt = n_cnt + 2'd1; fin = 1'b0;
                        end
                    end
                    M_EQSLASH: begin
                        n_t[n_cnt] = '{K_NE, o24(n_start), 16'd3, n_line, E_NONE, 1'b0};
                        n_cnt = n_cnt + 2'd1; n_mode = M_IDLE;
                    end
                    M_LT, M_GT: begin
                        n_t[n_cnt] = '{(b == 8'h3d) ? ((m == M_LT) ? K_LE : K_GE)
                                                    : ((m == M_LT) ? K_LT : K_GT),
                                       o24(n_start), (b == 8'h3d) ? 16'd2 : 16'd1,
                                       n_line, E_NONE, 1'b0};
                        n_cnt = n_cnt + 2'd1;
                        if (b == 8'h3d) n_mode = M_IDLE; else fin = 1'b0;
                    end
                    M_INT, M_FRAC: begin
                        if (is_dig(b)) n_len = ladd(n_len, 2'd1);
                        else if (m == M_INT && b == 8'h2e) n_mode = M_DOT;
                        else begin
                            n_t[n_cnt] = '{K_NUM, o24(n_start), n_len, n_line, E_NONE, 1'b0};
                            n_cnt = n_cnt + 2'd1; fin = 1'b0;
                        end
                    end
                    M_DOT: begin
                        n_len = ladd(n_len, 2'd2); n_mode = M_FRAC;
                    end
                    M_IDENT: begin
                        if (is_alp(b) || is_dig(b)) begin
                            if (n_len < 16'd7) n_kw[8*n_len[2:0] +: 8] = b;
                            n_len = ladd(n_len, 2'd1);
                        end else begin
                            n_t[n_cnt] = '{id_kind, o24(n_start), n_len, n_line,
                                           E_NONE, 1'b0};
                            n_cnt = n_cnt + 2'd1; fin = 1'b0;
                        end
                    end
                    M_STR: begin
                        if (b == 8'h00) begin
                            n_t[n_cnt] = '{K_ERR, o24(n_start), n_len, n_line, E_UNTERM, 1'b0};
                            n_cnt = n_cnt + 2'd1; fin = 1'b0;
                        end else begin
                            n_len = ladd(n_len, 2'd1);
                            if (b == 8'h22) begin
                                n_t[n_cnt] = '{K_STR, o24(n_start), n_len, n_line,
                                               E_NONE, 1'b0};
                                n_cnt = n_cnt + 2'd1; n_mode = M_IDLE;
                            end else if (b == 8'h0a) begin
                                if (n_line != 16'hFFFF) n_line = n_line + 16'd1;
                            end else if (b == 8'h25) n_mode = M_PCT;
                        end
                    end
                    M_PCT: begin
                        if (b != 8'h7b) begin
                            n_t[n_cnt] = '{K_ERR, o24(n_start), n_len, n_line,
                                           E_PERCENT, 1'b0};
                            n_cnt = n_cnt + 2'd1; fin = 1'b0;
                        end else if (32'(n_depth) >= INTERP_MAX) begin
                            n_t[n_cnt] = '{K_ERR, o24(n_start), n_len, n_line, E_DEEP, 1'b0};
                            n_cnt = n_cnt + 2'd1; fin = 1'b0;
                        end else begin
                            n_t[n_cnt] = '{K_INTERP, o24(n_start), ladd(n_len, 2'd1),
                                           n_line, E_NONE, 1'b0};
                            n_cnt = n_cnt + 2'd1;
                            brace_we = 1'b1; brace_wa = IW'(n_depth); brace_wd = 8'd1;
                            n_depth = n_depth + DW'(1); n_mode = M_IDLE;
                        end
                    end
                    default: fin = 1'b0;
                endcase
                // start of a new token from idle
                if (!fin) begin
                    n_mode = M_IDLE; n_start = o; n_len = 16'd1;
                    unique case (b) inside
                        8'h20, 8'h09, 8'h0d: ;
                        8'h0a: if (n_line != 16'hFFFF) n_line = n_line + 16'd1;
                        8'h00: begin
                            n_t[n_cnt] = '{K_EOF, o24(o), 16'd0, n_line, E_NONE, 1'b0};
                            n_cnt = n_cnt + 2'd1; rst = 1'b1;
                        end
                        8'h28, 8'h29, 8'h2c, 8'h2e, 8'h2d, 8'h2b, 8'h2a, 8'h5e, 8'h3b:
                        begin
                            n_t[n_cnt] = '{(b == 8'h28) ? K_LPAREN : (b == 8'h29) ? K_RPAREN :
                                           (b == 8'h2c) ? K_COMMA : (b == 8'h2e) ? K_DOT :
                                           (b == 8'h2d) ? K_MINUS : (b == 8'h2b) ? K_PLUS :
                                           (b == 8'h2a) ? K_STAR : (b == 8'h5e) ? K_CARET :
                                           K_SEMI, o24(o), 16'd1, n_line, E_NONE, 1'b0};
                            n_cnt = n_cnt + 2'd1;
                        end
                        8'h7b: begin
                            // only one brace byte per step, so the top entry is current
                            if (n_depth != '0 && r_top_bc != 8'hFF) begin
                                brace_we = 1'b1; brace_wa = top_i;
                                brace_wd = r_top_bc + 8'd1;
                            end
                            n_t[n_cnt] = '{K_LBRACE, o24(o), 16'd1, n_line, E_NONE, 1'b0};
                            n_cnt = n_cnt + 2'd1;
                        end
                        8'h7d: begin
                            if (n_depth != '0) begin
                                brace_we = 1'b1; brace_wa = top_i;
                                brace_wd = r_top_bc - 8'd1;
                            end
                            if (n_depth != '0 && r_top_bc == 8'd1) begin
                                n_depth = n_depth - DW'(1); n_mode = M_STR;
                                brace_pop = 1'b1;
                            end else begin
                                n_t[n_cnt] = '{K_RBRACE, o24(o), 16'd1, n_line, E_NONE, 1'b0};
                                n_cnt = n_cnt + 2'd1;
                            end
                        end
                        8'h2f: n_mode = M_SLASH;
                        8'h3d: n_mode = M_EQ;
                        8'h3c: n_mode = M_LT;
                        8'h3e: n_mode = M_GT;
                        8'h22: n_mode = M_STR;
                        default: begin
                            if (is_dig(b)) n_mode = M_INT;
                            else if (is_alp(b)) begin
                                n_kw = {48'd0, b}; n_mode = M_IDENT;
                            end else begin
                                n_t[n_cnt] = '{K_ERR, o24(o), 16'd1, n_line, E_UNKNOWN, 1'b0};
                                n_cnt = n_cnt + 2'd1;
                            end
                        end
                    endcase
                end
            end
        end
        if (n_cnt != 2'd0) n_t[n_cnt - 2'd1].last = 1'b1;
        if (rst) begin
            n_mode = M_IDLE; n_line = 16'd1; n_start = '0; n_len = 16'd0;
            n_kw = '0; n_depth = '0;
        end
    end

    // scanner registers: reset also on end of text
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_line <= 16'd1; r_off <= '0; r_start <= '0;
            r_len <= 16'd0; r_kw <= '0; r_depth <= '0; r_prev <= '0;
        end else if (acc) begin
            r_mode <= n_mode; r_line <= n_line; r_start <= n_start; r_len <= n_len;
            r_kw <= n_kw; r_depth <= n_depth;
            if (i_in.text_byte == 8'h00) begin
                r_off <= '0; r_prev <= '0;
            end else begin
                r_off <= (r_off == OFF_TOP) ? r_off : r_off + 1'b1;
                r_prev <= r_off;
            end
        end
    end

    // brace count store
    always_ff @(posedge i_clk) begin
        if (acc && brace_we) r_brace[brace_wa] <= brace_wd;
    end

    // innermost brace count: follow writes, reload the outer entry on close
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_bc <= 8'd0;
        end else if (acc && brace_pop) begin
            r_top_bc <= r_brace[top_i - IW'(1)];
        end else if (acc && brace_we) begin
            r_top_bc <= brace_wd;
        end
    end

    // result queue: load new tokens as the head leaves, else pop head
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qn <= 2'd0;
        end else begin
            if (acc) begin
                r_q[0] <= n_t[0]; r_q[1] <= n_t[1]; r_q[2] <= n_t[2];
                r_qn <= n_cnt;
            end else if (r_qn != 2'd0 && o_out.ready) begin
                r_q[0] <= r_q[1]; r_q[1] <= r_q[2]; r_qn <= r_qn - 2'd1;
            end
        end
    end

    assign o_out.valid        = r_qn != 2'd0;
    assign o_out.token_code   = r_q[0].kind;
    assign o_out.token_offset = r_q[0].offset;
    assign o_out.token_length = r_q[0].length;
    assign o_out.token_line   = r_q[0].line;
    assign o_out.error_code   = r_q[0].err;
    assign o_out.last_of_run  = r_q[0].last;
endmodule
`default_nettype wire

[test/tb.sv]
// Testbench: drives source text into the tokenizer and checks every token item.
module tb;
    import stt_pkg::*;

    localparam int INTERP_LIMIT = 8;
    localparam int WATCHDOG     = 5000;
    localparam int N_RANDOM     = 64;

    // scanner state of the predictor
    typedef enum int {
        S_IDLE, S_SLASH, S_COMMENT, S_EQ, S_EQSLASH, S_LT, S_GT,
        S_INT, S_DOT, S_FRAC, S_IDENT, S_STR, S_PCT
    } t_scan;

    typedef struct {
        logic [7:0] text;
        bit         has_tok;
        t_tok       tok;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    stt_byte_if in_if ();
    stt_tok_if  out_if ();

    source_text_tokenizer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    t_scan       scan;
    int unsigned line_cnt, cur_off, tok_start, tok_len, depth, prev_off;
    logic [55:0] kw_buf;
    int unsigned braces [INTERP_LIMIT];
    bit          was_eof;
    t_tok        step_toks [$];

    t_tok        pending_toks [$];
    logic [7:0]  text_q [$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          calm = 1'b0;
    int          in_gap = 0;
    int          out_gap = 0;

    function automatic bit is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] b);
        return b == "_" || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic int unsigned sat_len(int unsigned x, int unsigned n);
        return (x + n > 65535) ? 65535 : x + n;
    endfunction

    function automatic void clear_scanner();
        scan = S_IDLE;
        line_cnt = 1;
        cur_off = 0;
        tok_start = 0;
        tok_len = 0;
        kw_buf = '0;
        depth = 0;
        prev_off = 0;
        foreach (braces[i]) braces[i] = 0;
    endfunction

    function automatic void push_tok(logic [5:0] k, int unsigned off, int unsigned len,
                                     logic [2:0] e);
        t_tok t;
        t.kind = k;
        t.offset = off[23:0];
        t.length = len[15:0];
        t.line = line_cnt[15:0];
        t.err = e;
        t.last = 1'b0;
        step_toks.push_back(t);
    endfunction

    function automatic logic [5:0] word_kind();
        logic [55:0] mask;
        if (tok_len > 7) return K_IDENT;
        mask = (tok_len == 7) ? {56{1'b1}} : ((56'd1 << (8 * tok_len)) - 56'd1);
        for (int i = 0; i < NKW; i++)
            if (KW_LEN[i] == tok_len && (kw_buf & mask) == KW_TEXT[i])
                return K_KW0 + 6'(i);
        return K_IDENT;
    endfunction

    function automatic void open_token(logic [7:0] b, int unsigned off);
        tok_start = off;
        tok_len = 1;
        case (b)
            " ", "\t", 8'h0d: ;
            "\n": if (line_cnt < 65535) line_cnt++;
            8'h00: begin
                push_tok(K_EOF, off, 0, E_NONE);
                clear_scanner();
                was_eof = 1'b1;
            end
            "(": push_tok(K_LPAREN, off, 1, E_NONE);
            ")": push_tok(K_RPAREN, off, 1, E_NONE);
            ",": push_tok(K_COMMA, off, 1, E_NONE);
            ".": push_tok(K_DOT, off, 1, E_NONE);
            "-": push_tok(K_MINUS, off, 1, E_NONE);
            "+": push_tok(K_PLUS, off, 1, E_NONE);
            "*": push_tok(K_STAR, off, 1, E_NONE);
            "^": push_tok(K_CARET, off, 1, E_NONE);
            ";": push_tok(K_SEMI, off, 1, E_NONE);
            "{": begin
                if (depth > 0 && braces[depth-1] < 255) braces[depth-1]++;
                push_tok(K_LBRACE, off, 1, E_NONE);
            end
            "}": begin
                if (depth > 0) begin
                    braces[depth-1] = (braces[depth-1] - 1) & 8'hff;
                    if (braces[depth-1] == 0) begin
                        depth--;
                        scan = S_STR;
                        return;
                    end
                end
                push_tok(K_RBRACE, off, 1, E_NONE);
            end
            "/": scan = S_SLASH;
            "=": scan = S_EQ;
            "<": scan = S_LT;
            ">": scan = S_GT;
            "\"": scan = S_STR;
            default: begin
                if (is_digit(b)) scan = S_INT;
                else if (is_alpha(b)) begin
                    kw_buf = {48'd0, b};
                    scan = S_IDENT;
                end else push_tok(K_ERR, off, 1, E_UNKNOWN);
            end
        endcase
    endfunction

    // scan one byte; a byte that ends a pending token is scanned again from idle
    function automatic void scan_byte(logic [7:0] b, int unsigned off);
        t_scan m;
        m = scan;
        case (m)
            S_IDLE: begin
                open_token(b, off);
                return;
            end
            S_SLASH: begin
                if (b == "/") begin
                    tok_len = 2;
                    scan = S_COMMENT;
                    return;
                end
                push_tok(K_SLASH, tok_start, 1, E_NONE);
            end
            S_COMMENT: begin
                if (b != "\n" && b != 8'h00) begin
                    tok_len = sat_len(tok_len, 1);
                    return;
                end
                push_tok(K_COMMENT, tok_start, tok_len, E_NONE);
            end
            S_EQ: begin
                if (b == "/") begin
                    tok_len = 2;
                    scan = S_EQSLASH;
                    return;
                end
                if (b == "=") begin
                    push_tok(K_EQEQ, tok_start, 2, E_NONE);
                    scan = S_IDLE;
                    return;
                end
                push_tok(K_EQ, tok_start, 1, E_NONE);
            end
            S_EQSLASH: begin
                if (b == "=") begin
                    push_tok(K_NE, tok_start, 3, E_NONE);
                    scan = S_IDLE;
                    return;
                end
                push_tok(K_EQ, tok_start, 1, E_NONE);
                scan = S_IDLE;
                scan_byte("/", prev_off);
                scan_byte(b, off);
                return;
            end
            S_LT, S_GT: begin
                if (b == "=") begin
                    push_tok(m == S_LT ? K_LE : K_GE, tok_start, 2, E_NONE);
                    scan = S_IDLE;
                    return;
                end
                push_tok(m == S_LT ? K_LT : K_GT, tok_start, 1, E_NONE);
            end
            S_INT, S_FRAC: begin
                if (is_digit(b)) begin
                    tok_len = sat_len(tok_len, 1);
                    return;
                end
                if (m == S_INT && b == ".") begin
                    scan = S_DOT;
                    return;
                end
                push_tok(K_NUM, tok_start, tok_len, E_NONE);
            end
            S_DOT: begin
                if (is_digit(b)) begin
                    tok_len = sat_len(tok_len, 2);
                    scan = S_FRAC;
                    return;
                end
                push_tok(K_NUM, tok_start, tok_len, E_NONE);
                scan = S_IDLE;
                scan_byte(".", prev_off);
                scan_byte(b, off);
                return;
            end
            S_IDENT: begin
                if (is_alpha(b) || is_digit(b)) begin
                    if (tok_len < 7) kw_buf |= 56'(b) << (8 * tok_len);
                    tok_len = sat_len(tok_len, 1);
                    return;
                end
                push_tok(word_kind(), tok_start, tok_len, E_NONE);
            end
            S_STR: begin
                if (b == 8'h00) push_tok(K_ERR, tok_start, tok_len, E_UNTERM);
                else begin
                    tok_len = sat_len(tok_len, 1);
                    if (b == "\"") begin
                        push_tok(K_STR, tok_start, tok_len, E_NONE);
                        scan = S_IDLE;
                    end else if (b == "\n") begin
                        if (line_cnt < 65535) line_cnt++;
                    end else if (b == "%") scan = S_PCT;
                    return;
                end
            end
            S_PCT: begin
                if (b != "{") push_tok(K_ERR, tok_start, tok_len, E_PERCENT);
                else if (depth >= INTERP_LIMIT) push_tok(K_ERR, tok_start, tok_len, E_DEEP);
                else begin
                    push_tok(K_INTERP, tok_start, sat_len(tok_len, 1), E_NONE);
                    braces[depth] = 1;
                    depth++;
                    scan = S_IDLE;
                    return;
                end
            end
            default: ;
        endcase
        scan = S_IDLE;
        scan_byte(b, off);
    endfunction

    // predict the tokens caused by one accepted byte and queue them
    function automatic void predict_tokens(logic [7:0] b);
        int unsigned here;
        here = cur_off;
        step_toks.delete();
        was_eof = 1'b0;
        if (cur_off < 24'hffffff) cur_off++;
        scan_byte(b, here);
        if (!was_eof) prev_off = here;
        if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
        foreach (step_toks[i]) pending_toks.push_back(step_toks[i]);
    endfunction

    // drive the byte channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                predict_tokens(in_if.text_byte);
                void'(text_q.pop_front());
            end
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                in_if.valid <= 1'b0;
            end else if (!calm && (!in_if.valid || in_if.ready) && $urandom_range(0, 19) == 0)
            begin
                in_gap <= $urandom_range(0, 9);
                in_if.valid <= 1'b0;
            end else begin
                if (in_if.valid && in_if.ready) begin
                    if (text_q.size() > 0) in_if.text_byte <= text_q[0];
                    in_if.valid <= text_q.size() > 0;
                end else if (!in_if.valid) begin
                    if (text_q.size() > 0) in_if.text_byte <= text_q[0];
                    in_if.valid <= text_q.size() > 0;
                end
            end
        end
    end

    // stall the token channel and check each token item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                t_tok got;
                got.kind = out_if.token_code;
                got.offset = out_if.token_offset;
                got.length = out_if.token_length;
                got.line = out_if.token_line;
                got.err = out_if.error_code;
                got.last = out_if.last_of_run;
                if (pending_toks.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected token %p", got);
                end else begin
                    t_tok want;
                    want = pending_toks.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) $display("token mismatch: expected %p got %p",
                                                       want, got);
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                out_if.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 14) == 0) begin
                out_gap <= $urandom_range(0, 9);
                out_if.ready <= 1'b0;
            end else out_if.ready <= 1'b1;
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // directed rows: expected token typed in where obvious
    function automatic t_tok tk(logic [5:0] k, int off, int len, int ln, logic [2:0] e);
        t_tok t;
        t.kind = k;
        t.offset = 24'(off);
        t.length = 16'(len);
        t.line = 16'(ln);
        t.err = e;
        t.last = 1'b1;
        return t;
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endfunction

    // random fragments: words, operators, strings or a random nonzero byte
    function automatic string random_piece();
        string words [] = '{"e", "ou", "ka", "klasi", "keli", "si", "sinou", "super",
                            "falsu", "funson", "di", "divolvi", "ti", "timenti",
                            "imprimi", "verdadi", "mimoria", "nulo", "pa", "x_9",
                            "Zeta", "sinouX", "longername1"};
        string ops [] = '{"(", ")", "{", "}", ",", ".", "-", "+", "/", "*", "^", ";",
                          "=", "==", "=/=", "=/x", "<", "<=", ">", ">=", "12", "3.75",
                          "7.", "// note\n", "\n", " ", "\t", "\r"};
        string strs [] = '{"\"ab\"", "\"a%{x}b\"", "\"%{ {1} }\"", "\"q%z\"",
                            "\"l\nm\"", "\"%{\"%{y}\"}\""};
        case ($urandom_range(0, 9))
            0, 1, 2: return words[$urandom_range(0, words.size() - 1)];
            3, 4, 5, 6: return ops[$urandom_range(0, ops.size() - 1)];
            7, 8: return strs[$urandom_range(0, strs.size() - 1)];
            default: begin
                string s;
                s = " ";
                s[0] = 8'($urandom_range(1, 255));
                return s;
            end
        endcase
    endfunction

    t_row rows [$];

    initial begin
        t_row r;
        int unsigned target;
        in_if.valid = 1'b0;
        in_if.text_byte = 8'h00;
        out_if.ready = 1'b0;
        clear_scanner();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: single bytes with obvious tokens, then a text of specials
        r.has_tok = 1'b1;
        r.text = 8'h00; r.tok = tk(K_EOF, 0, 0, 1, E_NONE); rows.push_back(r);
        r.text = 8'hff; r.tok = tk(K_ERR, 0, 1, 1, E_UNKNOWN); rows.push_back(r);
        r.text = 8'h80; r.tok = tk(K_ERR, 1, 1, 1, E_UNKNOWN); rows.push_back(r);
        r.text = "%"; r.tok = tk(K_ERR, 2, 1, 1, E_UNKNOWN); rows.push_back(r);
        r.text = 8'h00; r.tok = tk(K_EOF, 3, 0, 1, E_NONE); rows.push_back(r);
        r.has_tok = 1'b0;
        foreach (rows[i]) text_q.push_back(rows[i].text);
        add_text("e ou ka klasi keli si sinou super falsu funson di divolvi ti timenti\n");
        add_text("imprimi verdadi mimoria nulo pa abcdefgh ()}{,.-+*^; = == =/= =/+ <= < >= >");
        add_text(" 1.5 2. 3x // c\n\"s%{a{b}}t\" \"p%q\" \"%{%{%{%{%{%{%{%{%{\" \"open");
        text_q.push_back(8'h00);
        // deeply nested interpolation closed again
        add_text("\"%{\"%{\"%{\"%{\"%{\"%{\"%{\"%{q}\"}\"}\"}\"}\"}\"}\"}\"}\"");
        text_q.push_back(8'h00);

        // random part: random fragments, each text ended by a zero byte
        target = N_RANDOM;
        while (target > 0) begin
            string p;
            p = random_piece();
            add_text(p);
            target = (target > p.len()) ? target - p.len() : 0;
            if ($urandom_range(0, 15) == 0) text_q.push_back(8'h00);
            if (text_q.size() > 200) wait (text_q.size() < 100);
        end
        text_q.push_back(8'h00);
        wait (text_q.size() < 20);
        calm = 1'b1;
        wait (text_q.size() == 0 && !in_if.valid && pending_toks.size() == 0);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && pending_toks.size() == 0) $display("PASS source_text_tokenizer_top");
        else $display("FAIL source_text_tokenizer_top");
        $finish;
    end

    // check typed-in expectations of the first directed rows
    initial begin
        int k;
        k = 0;
        wait (i_rst_n);
        while (k < 5) begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready) begin
                t_tok got;
                got = {out_if.token_code, out_if.token_offset, out_if.token_length,
                       out_if.token_line, out_if.error_code, out_if.last_of_run};
                if (got !== rows[k].tok) begin
                    mismatches++;
                    if (mismatches <= 10) $display("directed row %0d: expected %p got %p",
                                                   k, rows[k].tok, got);
                end
                k++;
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG) begin
            $display("FAIL source_text_tokenizer_top");
            $finish;
        end
    end
endmodule

[files.f]
rtl/stt_pkg.sv
rtl/stt_if.sv
rtl/source_text_tokenizer_top.sv
test/tb.sv
